### hdl/csvd_pkg.sv
// Package for the colour-space read Viterbi decoder.
// Holds shared types, constants and a tie-break function; no dependencies.
package csvd_pkg;

  localparam int NucW = 2;
  localparam logic [2:0] ColorUnknown = 3'd4;
  localparam logic [7:0] SnpPenaltyReset = 8'd30;

  typedef logic [NucW-1:0] nuc_t;

  // Lowest set bit of a four-bit tie mask, lowest index on ties.
  function automatic nuc_t lowest_bit(input logic [3:0] m);
    nuc_t r;
    r = 2'd0;
    if (m[0]) r = 2'd0;
    else if (m[1]) r = 2'd1;
    else if (m[2]) r = 2'd2;
    else if (m[3]) r = 2'd3;
    return r;
  endfunction

endpackage

### hdl/csvd_acs.sv
// Add-compare-select unit for one target state of the decoder.
// Depends on csvd_pkg.
module csvd_acs #(
  parameter int SW = 24
) (
  input  logic [SW-1:0] ps0,
  input  logic [SW-1:0] ps1,
  input  logic [SW-1:0] ps2,
  input  logic [SW-1:0] ps3,
  input  logic [1:0]    to,
  input  logic [2:0]    color,
  input  logic [7:0]    qual,
  input  logic          ref_bit,
  input  logic [7:0]    snp_penalty,
  output logic [SW-1:0] score,
  output logic [3:0]    tie
);
  import csvd_pkg::*;

  localparam logic [SW:0] SatMax = {1'b0, {SW{1'b1}}};

  logic [SW-1:0] ps [4];
  logic [SW-1:0] c [4];
  logic [SW-1:0] best;
  logic [SW:0]   sum;
  logic          known;

  always_comb begin
    ps[0] = ps0; ps[1] = ps1; ps[2] = ps2; ps[3] = ps3;
    known = (color < ColorUnknown);
    for (int j = 0; j < 4; j++) begin
      if (known && (2'(j) == (to ^ color[1:0]))) c[j] = ps[j];
      else begin
        sum = {1'b0, ps[j]} + (SW+1)'(qual);
        c[j] = (sum > SatMax) ? SatMax[SW-1:0] : sum[SW-1:0];
      end
    end
    best = c[0];
    tie = 4'b0001;
    for (int j = 1; j < 4; j++) begin
      if (c[j] < best) begin
        best = c[j];
        tie = 4'(1 << j);
      end else if (c[j] == best) tie[j] = 1'b1;
    end
    sum = {1'b0, best} + (ref_bit ? '0 : (SW+1)'(snp_penalty));
    score = (sum > SatMax) ? SatMax[SW-1:0] : sum[SW-1:0];
  end
endmodule

### hdl/colorspace_read_viterbi_decoder_top.sv
// Colour-space read Viterbi decoder, top level.
// Forward step: one shared add-compare-select unit serves one state a cycle; an item passes
// through the accepting state, four state updates and the path memory write (the first item
// of a read goes straight to the write). After the last item a step picks the best final state;
// traceback reads one stored mask per position and emits one base each, stalling until the prior
// output is taken. Reset is synchronous, active low; clears scores, count, overflow, penalty 30.
module colorspace_read_viterbi_decoder_top #(
  parameter int MAX_POSITIONS = 64,
  parameter int SCORE_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ref_mask[3:0], color[6:4], qual[14:7]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // nucleotide, position, ref_mismatch, has_color,
                                  // color_mismatch, decoded_color, best_score,
                                  // snp_count, color_mismatch_count, overflow
  output logic        out_tlast
);
  import csvd_pkg::*;

  localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int CW = $clog2(MAX_POSITIONS + 1);
  localparam logic [SCORE_WIDTH:0] SatMax = {1'b0, {SCORE_WIDTH{1'b1}}};

  typedef enum logic [2:0] {S_IDLE, S_FWD, S_WRITE, S_BEST, S_READ, S_EMIT} state_t;

  state_t state_r;
  logic [7:0] snp_r;
  logic [SCORE_WIDTH-1:0] ps_r [4];
  logic [SCORE_WIDTH-1:0] nx_r [4];
  logic [15:0] tie_r;
  logic [CW-1:0] cnt_r;
  logic ovf_r;
  logic [3:0] ref_r;
  logic [2:0] col_r;
  logic [7:0] q_r;
  logic last_r;
  logic [1:0] st_r;

  logic [15:0] bt_mem [MAX_POSITIONS];
  logic [3:0]  rm_mem [MAX_POSITIONS];
  logic [2:0]  cl_mem [MAX_POSITIONS];
  logic [15:0] bt_q_r;
  logic [3:0]  rm_q_r;
  logic [2:0]  cl_q_r;

  // Traceback state
  logic [CW-1:0] idx_r;
  nuc_t to_r, next_r;
  logic [2:0] ncol_r;
  logic [SCORE_WIDTH-1:0] best_r;
  logic [6:0] snps_r;
  logic [5:0] cmms_r;
  logic [55:0] od_r;
  logic ol_r, ov_r;

  logic [SCORE_WIDTH-1:0] acs_score;
  logic [3:0] acs_tie;
  logic [SCORE_WIDTH:0] s0;

  csvd_acs #(.SW(SCORE_WIDTH)) u_acs (
    .ps0(ps_r[0]), .ps1(ps_r[1]), .ps2(ps_r[2]), .ps3(ps_r[3]),
    .to(st_r), .color(col_r), .qual(q_r), .ref_bit(ref_r[st_r]),
    .snp_penalty(snp_r), .score(acs_score), .tie(acs_tie)
  );

  assign s0 = (SCORE_WIDTH+1)'(snp_r);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  logic [AW-1:0] widx;
  assign widx = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && cnt_r < CW'(MAX_POSITIONS)) begin
      bt_mem[widx] <= (cnt_r == '0) ? 16'hFFFF : tie_r;
      rm_mem[widx] <= ref_r;
      cl_mem[widx] <= col_r;
    end
    bt_q_r <= bt_mem[idx_r[AW-1:0]];
    rm_q_r <= rm_mem[idx_r[AW-1:0]];
    cl_q_r <= cl_mem[AW'(idx_r + 1'b1)];
  end

  logic rm, cm, hc;
  logic [1:0] dc;
  always_comb begin
    rm = ~rm_q_r[to_r];
    hc = (idx_r + 1'b1) < cnt_r;
    dc = hc ? (to_r ^ next_r) : 2'd0;
    cm = hc && ((cl_q_r >= ColorUnknown) || (cl_q_r[1:0] != dc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      snp_r <= SnpPenaltyReset;
      for (int s = 0; s < 4; s++) ps_r[s] <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) snp_r <= cfg_data;
          if (in_tvalid) begin
            ref_r <= in_tdata[3:0];
            col_r <= in_tdata[6:4];
            q_r <= in_tdata[14:7];
            last_r <= in_tlast;
            st_r <= 2'd0;
            if (cnt_r < CW'(MAX_POSITIONS)) state_r <= (cnt_r == '0) ? S_WRITE : S_FWD;
            else begin
              ovf_r <= 1'b1;
              state_r <= in_tlast ? S_BEST : S_IDLE;
            end
          end
        end
        S_FWD: begin
          nx_r[st_r] <= acs_score;
          tie_r[4*st_r +: 4] <= acs_tie;
          st_r <= st_r + 2'd1;
          if (st_r == 2'd3) state_r <= S_WRITE;
        end
        S_WRITE: begin
          for (int s = 0; s < 4; s++) begin
            if (cnt_r == '0)
              ps_r[s] <= ref_r[s] ? '0 : ((s0 > SatMax) ? SatMax[SCORE_WIDTH-1:0]
                                                       : s0[SCORE_WIDTH-1:0]);
            else ps_r[s] <= nx_r[s];
          end
          cnt_r <= cnt_r + 1'b1;
          state_r <= last_r ? S_BEST : S_IDLE;
        end
        S_BEST: begin
          begin : pick
            logic [1:0] b;
            b = 2'd0;
            for (int s = 1; s < 4; s++) if (ps_r[s] < ps_r[b]) b = 2'(s);
            to_r <= b;
            best_r <= ps_r[b];
          end
          idx_r <= cnt_r - 1'b1;
          snps_r <= '0;
          cmms_r <= '0;
          next_r <= '0;
          state_r <= S_READ;
        end
        S_READ: begin
          if (!ov_r || out_tready) state_r <= S_EMIT;
        end
        S_EMIT: begin
          begin : emit
            logic [6:0] ns;
            logic [5:0] nc;
            ns = (rm && snps_r != 7'd127) ? snps_r + 7'd1 : snps_r;
            nc = (cm && cmms_r != 6'd63) ? cmms_r + 6'd1 : cmms_r;
            snps_r <= ns;
            cmms_r <= nc;
            od_r <= {5'd0, ovf_r, nc, ns, 24'(best_r), dc, cm, hc, rm,
                     6'(idx_r), to_r};
            ol_r <= (idx_r == '0);
            ov_r <= 1'b1;
            next_r <= to_r;
            to_r <= lowest_bit(bt_q_r[4*to_r +: 4]);
            if (idx_r == '0) begin
              for (int s = 0; s < 4; s++) ps_r[s] <= '0;
              cnt_r <= '0;
              ovf_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
